// ===== src/cds_pkg.sv =====
// Shared constants and types for the cone direction sampler.
// Holds trig series constants, config register codes and the frame struct.
// Depends on nothing.
`default_nettype none
package cds_pkg;

	// trig datapath works at 30 fraction bits
	localparam int TRIG_BITS = 30;
	localparam int NUM_TERMS = 6;
	localparam logic [30:0] TRIG_ONE = 31'h4000_0000;

	// 2*pi at 44 fraction bits, split into two 24-bit halves
	localparam logic [23:0] TWO_PI_HI = 24'h6487ED;
	localparam logic [23:0] TWO_PI_LO = 24'h5110B4;

	// Horner divisors and floor(2^32 / d) reciprocals
	localparam logic [7:0] SIN_DIV [NUM_TERMS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
	localparam logic [7:0] COS_DIV [NUM_TERMS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
	localparam logic [31:0] SIN_RECIP [NUM_TERMS] = '{
		32'd27531841, 32'd39045157, 32'd59652323,
		32'd102261126, 32'd214748364, 32'd715827882};
	localparam logic [31:0] COS_RECIP [NUM_TERMS] = '{
		32'd32537631, 32'd47721858, 32'd76695844,
		32'd143165576, 32'd357913941, 32'd2147483648};

	// angle front end, Horner steps, final product and quadrant select
	localparam int SINCOS_LAT = 4 + 3 * NUM_TERMS + 3;
	localparam int ROT_LAT = 3;

	typedef enum logic [2:0] {
		CFG_CONE_COS  = 3'd0,
		CFG_FRAME_I   = 3'd1,
		CFG_FRAME_J   = 3'd2,
		CFG_FRAME_DIR = 3'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [53:0] i_axis;
		logic [53:0] j_axis;
		logic [53:0] dir_axis;
	} frame_t;

endpackage
`default_nettype wire

// ===== src/cds_delay.sv =====
// Enabled delay line used to line up the sampler's parallel lanes.
// Depends on nothing.
`default_nettype none
module cds_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [WIDTH-1:0] din,
	output logic      [WIDTH-1:0] dout
);
	generate
		if (DEPTH == 0) begin : g_none
			assign dout = din;
		end else begin : g_line
			logic [WIDTH-1:0] tap_q [DEPTH];
			// shift the word along while the pipeline advances
			always_ff @(posedge clk) begin
				if (en) begin
					tap_q[0] <= din;
					for (int i = 1; i < DEPTH; i++) begin
						tap_q[i] <= tap_q[i-1];
					end
				end
			end
			assign dout = tap_q[DEPTH-1];
		end
	endgenerate
endmodule
`default_nettype wire

// ===== src/cds_sincos.sv =====
// Pipelined cosine and sine of 2*pi*r1 for the cone direction sampler.
// Octant fold, Horner series in Q30, quadrant select; uses cds_pkg.
`default_nettype none
module cds_sincos #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [15:0]                 azimuth_fraction,
	output logic signed [FRAC_BITS+1:0]      cos_val,
	output logic signed [FRAC_BITS+1:0]      sin_val
);
	import cds_pkg::*;

	localparam int SH = TRIG_BITS - FRAC_BITS;
	localparam logic signed [31:0] RND_OUT = 32'sd1 <<< (SH - 1);
	localparam logic [1:0] QUAD_I = 2'd0;
	localparam logic [1:0] QUAD_II = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;

	// fold the angle into the first octant
	logic [1:0]  quad;
	logic [13:0] uoff;
	logic        swap;
	logic [13:0] ufold;
	always_comb begin
		quad = azimuth_fraction[15:14];
		uoff = azimuth_fraction[13:0];
		swap = uoff > 14'h2000;
		ufold = swap ? 14'(15'h4000 - {1'b0, uoff}) : uoff;
	end

	// stage 1: partial products of u * 2*pi
	logic [37:0] xph_s1, xpl_s1;
	logic [1:0]  quad_s1;
	logic        swap_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			xph_s1 <= 38'(ufold) * 38'(TWO_PI_HI);
			xpl_s1 <= 38'(ufold) * 38'(TWO_PI_LO);
			quad_s1 <= quad;
			swap_s1 <= swap;
		end
	end

	// stage 2: combine and round to Q30 radians
	logic [62:0] xsum;
	logic [29:0] x_s2;
	logic [1:0]  quad_s2;
	logic        swap_s2;
	assign xsum = 63'({xph_s1, 24'h0}) + 63'(xpl_s1) + 63'h2000_0000;
	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= xsum[59:30];
			quad_s2 <= quad_s1;
			swap_s2 <= swap_s1;
		end
	end

	// stage 3: square the angle
	logic [59:0] x2p_s3;
	logic [29:0] x_s3;
	logic [1:0]  quad_s3;
	logic        swap_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			x2p_s3 <= 60'(x_s2) * 60'(x_s2);
			x_s3 <= x_s2;
			quad_s3 <= quad_s2;
			swap_s3 <= swap_s2;
		end
	end

	// stage 4: round the square
	logic [59:0] x2sum;
	logic [29:0] x2_s4, x_s4;
	logic [1:0]  quad_s4;
	logic        swap_s4;
	assign x2sum = x2p_s3 + 60'h2000_0000;
	always_ff @(posedge clk) begin
		if (en) begin
			x2_s4 <= x2sum[59:30];
			x_s4 <= x_s3;
			quad_s4 <= quad_s3;
			swap_s4 <= swap_s3;
		end
	end

	// Horner step inputs, one entry per step boundary
	logic [30:0] ps_v [NUM_TERMS+1];
	logic [30:0] pc_v [NUM_TERMS+1];
	logic [29:0] x2_v [NUM_TERMS+1];
	logic [29:0] x_v [NUM_TERMS+1];
	logic [1:0]  quad_v [NUM_TERMS+1];
	logic        swap_v [NUM_TERMS+1];

	assign ps_v[0] = TRIG_ONE;
	assign pc_v[0] = TRIG_ONE;
	assign x2_v[0] = x2_s4;
	assign x_v[0] = x_s4;
	assign quad_v[0] = quad_s4;
	assign swap_v[0] = swap_s4;

	generate
		for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
			logic [60:0] sprod_s1, cprod_s1;
			logic [29:0] x2_s1, xa_s1;
			logic [1:0]  qd_s1;
			logic        sw_s1;
			logic [60:0] srnd, crnd;
			logic [30:0] st_s2, ct_s2;
			logic [62:0] sm_s2, cm_s2;
			logic [29:0] x2_s2, xa_s2;
			logic [1:0]  qd_s2;
			logic        sw_s2;
			logic [30:0] sq0, cq0, sq, cq;
			logic [31:0] srem, crem;
			logic [30:0] ps_s3, pc_s3;
			logic [29:0] x2_s3, xa_s3;
			logic [1:0]  qd_s3;
			logic        sw_s3;

			// multiply the running term by x^2
			always_ff @(posedge clk) begin
				if (en) begin
					sprod_s1 <= 61'(x2_v[k]) * 61'(ps_v[k]);
					cprod_s1 <= 61'(x2_v[k]) * 61'(pc_v[k]);
					x2_s1 <= x2_v[k];
					xa_s1 <= x_v[k];
					qd_s1 <= quad_v[k];
					sw_s1 <= swap_v[k];
				end
			end

			// round to Q30 and multiply by the reciprocal of the divisor
			assign srnd = sprod_s1 + 61'h2000_0000;
			assign crnd = cprod_s1 + 61'h2000_0000;
			always_ff @(posedge clk) begin
				if (en) begin
					st_s2 <= srnd[60:30];
					ct_s2 <= crnd[60:30];
					sm_s2 <= 63'(srnd[60:30]) * 63'(SIN_RECIP[k]);
					cm_s2 <= 63'(crnd[60:30]) * 63'(COS_RECIP[k]);
					x2_s2 <= x2_s1;
					xa_s2 <= xa_s1;
					qd_s2 <= qd_s1;
					sw_s2 <= sw_s1;
				end
			end

			// fix the quotient estimate by one and subtract from one
			always_comb begin
				sq0 = sm_s2[62:32];
				cq0 = cm_s2[62:32];
				srem = 32'(st_s2) - 32'(sq0) * 32'(SIN_DIV[k]);
				crem = 32'(ct_s2) - 32'(cq0) * 32'(COS_DIV[k]);
				sq = sq0 + 31'(srem >= 32'(SIN_DIV[k]));
				cq = cq0 + 31'(crem >= 32'(COS_DIV[k]));
			end
			always_ff @(posedge clk) begin
				if (en) begin
					ps_s3 <= TRIG_ONE - sq;
					pc_s3 <= TRIG_ONE - cq;
					x2_s3 <= x2_s2;
					xa_s3 <= xa_s2;
					qd_s3 <= qd_s2;
					sw_s3 <= sw_s2;
				end
			end

			assign ps_v[k+1] = ps_s3;
			assign pc_v[k+1] = pc_s3;
			assign x2_v[k+1] = x2_s3;
			assign x_v[k+1] = xa_s3;
			assign quad_v[k+1] = qd_s3;
			assign swap_v[k+1] = sw_s3;
		end
	endgenerate

	// sine needs one more product with x
	logic [60:0] sp_f1;
	logic [30:0] c_f1;
	logic [1:0]  quad_f1;
	logic        swap_f1;
	always_ff @(posedge clk) begin
		if (en) begin
			sp_f1 <= 61'(x_v[NUM_TERMS]) * 61'(ps_v[NUM_TERMS]);
			c_f1 <= pc_v[NUM_TERMS];
			quad_f1 <= quad_v[NUM_TERMS];
			swap_f1 <= swap_v[NUM_TERMS];
		end
	end

	logic [60:0] sprnd;
	logic [30:0] s_f2, c_f2;
	logic [1:0]  quad_f2;
	logic        swap_f2;
	assign sprnd = sp_f1 + 61'h2000_0000;
	always_ff @(posedge clk) begin
		if (en) begin
			s_f2 <= sprnd[60:30];
			c_f2 <= c_f1;
			quad_f2 <= quad_f1;
			swap_f2 <= swap_f1;
		end
	end

	// unfold octant and quadrant, then round to the inner format
	logic signed [31:0] oa, ob, cq_w, sq_w, cr_w, sr_w;
	always_comb begin
		oa = swap_f2 ? $signed({1'b0, s_f2}) : $signed({1'b0, c_f2});
		ob = swap_f2 ? $signed({1'b0, c_f2}) : $signed({1'b0, s_f2});
		unique case (quad_f2)
			QUAD_I: begin
				cq_w = oa;
				sq_w = ob;
			end
			QUAD_II: begin
				cq_w = -ob;
				sq_w = oa;
			end
			QUAD_III: begin
				cq_w = -oa;
				sq_w = -ob;
			end
			default: begin
				cq_w = ob;
				sq_w = -oa;
			end
		endcase
		cr_w = (cq_w + RND_OUT) >>> SH;
		sr_w = (sq_w + RND_OUT) >>> SH;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cos_val <= (FRAC_BITS+2)'(cr_w);
			sin_val <= (FRAC_BITS+2)'(sr_w);
		end
	end
endmodule
`default_nettype wire

// ===== src/cds_height.sv =====
// Height lane of the cone direction sampler: z from r2 and the cone cosine,
// then a pipelined square root of 1 - z*z, one result bit per stage.
`default_nettype none
module cds_height #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [15:0]                 height_fraction,
	input  wire logic [17:0]                 cone_cos,
	output logic signed [FRAC_BITS+1:0]      z_val,
	output logic        [FRAC_BITS:0]        radial
);
	import cds_pkg::*;

	localparam int F = FRAC_BITS;
	localparam int RW = 2 * F + 2;
	localparam int W = F + 3;
	localparam logic [F+1:0] ONE_G = {2'b01, {F{1'b0}}};
	localparam logic [2*F+2:0] RND_P = (2*F+3)'(1) << (F - 1);
	localparam logic signed [17:0] POS_ONE = 18'sd65536;
	localparam logic signed [17:0] NEG_ONE = -18'sd65536;

	// clamp the cosine and bring both values to the inner format
	logic signed [17:0]  cc, cc_cl;
	logic signed [F+1:0] cf;
	logic        [F:0]   r2f;
	logic signed [F+2:0] gam_w;
	logic        [F+1:0] gamma;
	assign cc = $signed(cone_cos);
	assign cc_cl = (cc > POS_ONE) ? POS_ONE : ((cc < NEG_ONE) ? NEG_ONE : cc);

	generate
		if (F >= 16) begin : g_up
			assign cf = (F+2)'(cc_cl) <<< (F - 16);
			assign r2f = (F+1)'(height_fraction) << (F - 16);
		end else begin : g_down
			localparam logic signed [18:0] CF_RND = 19'sd1 <<< (15 - F);
			localparam logic [16:0] R2_RND = 17'd1 << (15 - F);
			logic signed [18:0] cf_w;
			logic        [16:0] r2_w;
			assign cf_w = (19'(cc_cl) + CF_RND) >>> (16 - F);
			assign r2_w = ({1'b0, height_fraction} + R2_RND) >> (16 - F);
			assign cf = (F+2)'(cf_w);
			assign r2f = (F+1)'(r2_w);
		end
	endgenerate

	assign gam_w = $signed({1'b0, ONE_G}) - (F+3)'(cf);
	assign gamma = gam_w[F+1:0];

	// stage 1: r2 times (1 - cos)
	logic [2*F+2:0] prod_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (2*F+3)'(r2f) * (2*F+3)'(gamma);
		end
	end

	// stage 2: form z and square it
	logic [2*F+2:0]      psum;
	logic [F+2:0]        sc;
	logic signed [F+3:0] zw;
	logic signed [F+1:0] zc;
	logic signed [2*F+3:0] zsq_w;
	logic signed [F+1:0] z_s2;
	logic [2*F:0]        zsq_s2;
	always_comb begin
		psum = prod_s1 + RND_P;
		sc = (F+3)'(psum >> F);
		zw = $signed((F+4)'(ONE_G)) - $signed((F+4)'(sc));
		zc = (F+2)'(zw);
		zsq_w = (2*F+4)'(zc) * (2*F+4)'(zc);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			z_s2 <= zc;
			zsq_s2 <= zsq_w[2*F:0];
		end
	end

	// stage 3: 1 - z^2, clamped at zero, scaled for the root
	logic [2*F+1:0]      zzsum;
	logic [F:0]          zz;
	logic signed [F+2:0] rem_w;
	logic [F:0]          rem;
	logic signed [F+1:0] z_s3;
	logic [RW-1:0]       rad_s3;
	always_comb begin
		zzsum = (2*F+2)'(zsq_s2) + (2*F+2)'(RND_P);
		zz = (F+1)'(zzsum >> F);
		rem_w = $signed((F+3)'(ONE_G)) - $signed((F+3)'(zz));
		rem = (rem_w < 0) ? '0 : rem_w[F:0];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			z_s3 <= z_s2;
			rad_s3 <= {1'b0, rem, {F{1'b0}}};
		end
	end

	// square root: one result bit per stage
	logic [W-1:0]        rem_v [F+2];
	logic [W-1:0]        root_v [F+2];
	logic [RW-1:0]       rad_v [F+2];
	logic signed [F+1:0] zd_v [F+2];
	assign rem_v[0] = '0;
	assign root_v[0] = '0;
	assign rad_v[0] = rad_s3;
	assign zd_v[0] = z_s3;

	generate
		for (genvar i = 0; i <= F; i++) begin : g_root
			logic [W-1:0]        remn, trial;
			logic                ge;
			logic [W-1:0]        rem_s1, root_s1;
			logic [RW-1:0]       rad_s1;
			logic signed [F+1:0] z_s1;
			always_comb begin
				remn = {rem_v[i][W-3:0], rad_v[i][RW-1:RW-2]};
				trial = {root_v[i][W-3:0], 2'b01};
				ge = remn >= trial;
			end
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s1 <= ge ? remn - trial : remn;
					root_s1 <= {root_v[i][W-2:0], ge};
					rad_s1 <= rad_v[i] << 2;
					z_s1 <= zd_v[i];
				end
			end
			assign rem_v[i+1] = rem_s1;
			assign root_v[i+1] = root_s1;
			assign rad_v[i+1] = rad_s1;
			assign zd_v[i+1] = z_s1;
		end
	endgenerate

	assign radial = root_v[F+1][F:0];
	assign z_val = zd_v[F+1];
endmodule
`default_nettype wire

// ===== src/cds_rot.sv =====
// Frame rotation of the local direction and Q1.16 saturation.
// Uses cds_pkg for the frame struct.
`default_nettype none
module cds_rot #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic signed [FRAC_BITS+1:0] cos_val,
	input  wire logic signed [FRAC_BITS+1:0] sin_val,
	input  wire logic signed [FRAC_BITS+1:0] z_val,
	input  wire logic        [FRAC_BITS:0]   radial,
	input  wire cds_pkg::frame_t             frame,
	output logic signed [17:0]               ray_x,
	output logic signed [17:0]               ray_y,
	output logic signed [17:0]               ray_z
);
	import cds_pkg::*;

	localparam int F = FRAC_BITS;
	localparam int PW = F + 20;
	localparam int SW = F + 22;
	localparam logic signed [2*F+3:0] RND_L = (2*F+4)'(1) <<< (F - 1);
	localparam logic signed [SW-1:0] RND_S = SW'(1) <<< (F - 1);
	localparam logic signed [SW-1:0] SAT_HI = SW'(65536);
	localparam logic signed [SW-1:0] SAT_LO = -SW'(65536);

	// stage 1: scale cos and sin by the radius
	logic signed [2*F+3:0] px_s1, py_s1;
	logic signed [F+1:0]   z_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= (2*F+4)'(cos_val) * $signed((2*F+4)'(radial));
			py_s1 <= (2*F+4)'(sin_val) * $signed((2*F+4)'(radial));
			z_s1 <= z_val;
		end
	end

	// stage 2: round the local direction and multiply by each axis
	logic signed [2*F+3:0] lxw, lyw;
	logic signed [F+1:0]   lx, ly;
	logic signed [PW-1:0]  pi_s2 [3];
	logic signed [PW-1:0]  pj_s2 [3];
	logic signed [PW-1:0]  pd_s2 [3];
	assign lxw = (px_s1 + RND_L) >>> F;
	assign lyw = (py_s1 + RND_L) >>> F;
	assign lx = (F+2)'(lxw);
	assign ly = (F+2)'(lyw);
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				pi_s2[a] <= PW'($signed(frame.i_axis[18*a +: 18])) * PW'(lx);
				pj_s2[a] <= PW'($signed(frame.j_axis[18*a +: 18])) * PW'(ly);
				pd_s2[a] <= PW'($signed(frame.dir_axis[18*a +: 18])) * PW'(z_s1);
			end
		end
	end

	// stage 3: sum, round to Q1.16 and saturate
	logic signed [SW-1:0] rsum [3];
	logic signed [SW-1:0] rsat [3];
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			rsum[a] = (SW'(pi_s2[a]) + SW'(pj_s2[a]) + SW'(pd_s2[a]) + RND_S) >>> F;
			if (rsum[a] > SAT_HI) begin
				rsat[a] = SAT_HI;
			end else if (rsum[a] < SAT_LO) begin
				rsat[a] = SAT_LO;
			end else begin
				rsat[a] = rsum[a];
			end
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ray_x <= 18'(rsat[0]);
			ray_y <= 18'(rsat[1]);
			ray_z <= 18'(rsat[2]);
		end
	end
endmodule
`default_nettype wire

// ===== src/cone_direction_sampler.sv =====
// Cone direction sampler: one direction drawn over a spherical cap per word.
// Input channel in_valid/in_ready carries azimuth_fraction and height_fraction
// (uniform fractions scaled by 65536). Output channel out_valid/out_ready
// carries ray_x, ray_y, ray_z in signed Q1.16, saturated to +-1.
// Config channel cfg_valid/cfg_ready writes cone_cos (index 0) and the frame
// axes i, j, dir (indexes 1..3) from cfg_data; other indexes are dropped.
// cfg_ready is always high; write only while no word is in flight.
// Throughput is one word per clock while the output is not stalled. Each word
// passes through the longer of the sine/cosine series lane (six Horner steps
// of three stages) and the one-bit-per-stage square root lane, followed by
// three rotation stages ending in the output register.
// The whole pipeline advances together; when out_valid is high and
// out_ready is low, every stage holds and in_ready drops, so nothing is lost.
// Reset empties the pipeline and loads cone_cos = -1 and the identity frame.
// Uses cds_pkg, cds_sincos, cds_height, cds_delay and cds_rot.
`default_nettype none
module cone_direction_sampler #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [15:0]        azimuth_fraction,
	input  wire logic [15:0]        height_fraction,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [17:0]      ray_x,
	output logic signed [17:0]      ray_y,
	output logic signed [17:0]      ray_z,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [53:0]        cfg_data
);
	import cds_pkg::*;

	localparam int HT_LAT = FRAC_BITS + 4;
	localparam int LANE_LAT = (SINCOS_LAT > HT_LAT) ? SINCOS_LAT : HT_LAT;
	localparam int TOTAL_LAT = LANE_LAT + ROT_LAT;
	localparam int SC_W = 2 * (FRAC_BITS + 2);
	localparam int HT_W = 2 * FRAC_BITS + 3;

	// configuration registers
	logic [17:0] cone_cos_q;
	frame_t      frame_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cone_cos_q <= 18'h30000;
			frame_q.i_axis <= 54'd65536;
			frame_q.j_axis <= 54'd17179869184;
			frame_q.dir_axis <= 54'd4503599627370496;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CONE_COS: cone_cos_q <= cfg_data[17:0];
				CFG_FRAME_I: frame_q.i_axis <= cfg_data;
				CFG_FRAME_J: frame_q.j_axis <= cfg_data;
				CFG_FRAME_DIR: frame_q.dir_axis <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance the whole pipeline unless the output word is stuck
	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// valid bits travel alongside the data
	logic [TOTAL_LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[TOTAL_LAT-1];

	// azimuth lane
	logic signed [FRAC_BITS+1:0] cos_raw, sin_raw, cos_al, sin_al;
	cds_sincos #(.FRAC_BITS(FRAC_BITS)) u_sincos (
		.clk(clk),
		.en(en),
		.azimuth_fraction(azimuth_fraction),
		.cos_val(cos_raw),
		.sin_val(sin_raw)
	);

	logic [SC_W-1:0] sc_out;
	cds_delay #(.WIDTH(SC_W), .DEPTH(LANE_LAT - SINCOS_LAT)) u_sc_pad (
		.clk(clk),
		.en(en),
		.din({cos_raw, sin_raw}),
		.dout(sc_out)
	);
	assign cos_al = sc_out[SC_W-1:FRAC_BITS+2];
	assign sin_al = sc_out[FRAC_BITS+1:0];

	// height lane
	logic signed [FRAC_BITS+1:0] z_raw, z_al;
	logic        [FRAC_BITS:0]   rad_raw, rad_al;
	cds_height #(.FRAC_BITS(FRAC_BITS)) u_height (
		.clk(clk),
		.en(en),
		.height_fraction(height_fraction),
		.cone_cos(cone_cos_q),
		.z_val(z_raw),
		.radial(rad_raw)
	);

	logic [HT_W-1:0] ht_out;
	cds_delay #(.WIDTH(HT_W), .DEPTH(LANE_LAT - HT_LAT)) u_ht_pad (
		.clk(clk),
		.en(en),
		.din({z_raw, rad_raw}),
		.dout(ht_out)
	);
	assign z_al = ht_out[HT_W-1:FRAC_BITS+1];
	assign rad_al = ht_out[FRAC_BITS:0];

	// rotation into the world frame
	cds_rot #(.FRAC_BITS(FRAC_BITS)) u_rot (
		.clk(clk),
		.en(en),
		.cos_val(cos_al),
		.sin_val(sin_al),
		.z_val(z_al),
		.radial(rad_al),
		.frame(frame_q),
		.ray_x(ray_x),
		.ray_y(ray_y),
		.ray_z(ray_z)
	);

`ifndef SYNTHESIS
	// a stalled pipeline keeps its occupancy
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

	// an accepted word occupies the first stage next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted word dropped at entry");

	// delivered components stay within +-1
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ray_x <= 18'sd65536) && (ray_x >= -18'sd65536)
			&& (ray_y <= 18'sd65536) && (ray_y >= -18'sd65536)
			&& (ray_z <= 18'sd65536) && (ray_z >= -18'sd65536))
		else $error("output component out of range");
`endif
endmodule
`default_nettype wire
